// ----- hw/rtl/jse_pkg.sv -----
// ----------------------------------------------------------------------------
// JSON string escaper package
// Shared types, character constants and the per-byte escape function.
// ----------------------------------------------------------------------------
package jse_pkg;

   localparam int unsigned BodyMax = 6;

   localparam logic [7:0] QUOTE_CHAR  = 8'h22;
   localparam logic [7:0] BSLASH_CHAR = 8'h5c;
   localparam logic [7:0] U_CHAR      = 8'h75;
   localparam logic [7:0] ZERO_CHAR   = 8'h30;
   localparam logic [7:0] CTRL_MAX    = 8'h1f;
   localparam logic [7:0] DEL_CHAR    = 8'h7f;
   localparam logic [7:0] HIGH_MARK   = 8'h80;
   localparam logic [7:0] LEAD_MARK   = 8'hc0;
   localparam logic [7:0] LOW6_MASK   = 8'h3f;

   typedef logic [2:0] len_type;

   // One accepted input item.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       starts_string;
      logic       ends_string;
      logic       text_is_utf8;
   } item_type;

   // Escaped body of one item, framed by optional quotes.
   typedef struct packed {
      logic [BodyMax-1:0][7:0] body;
      len_type                 len;
      logic                    starts_string;
      logic                    ends_string;
   } seg_type;

   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      logic [7:0] d;
      if (nib < 4'd10) begin
         d = ZERO_CHAR + {4'd0, nib};
      end else begin
         d = 8'h57 + {4'd0, nib};
      end
      return d;
   endfunction

   function automatic seg_type escape_item(input item_type it);
      seg_type    s;
      logic [7:0] x;
      logic [7:0] shortc;
      x = it.data_byte;
      s.body = '0;
      s.starts_string = it.starts_string;
      s.ends_string = it.ends_string;
      case (x)
         QUOTE_CHAR:  shortc = QUOTE_CHAR;
         BSLASH_CHAR: shortc = BSLASH_CHAR;
         8'h08:       shortc = 8'h62;
         8'h09:       shortc = 8'h74;
         8'h0a:       shortc = 8'h6e;
         8'h0c:       shortc = 8'h66;
         8'h0d:       shortc = 8'h72;
         default:     shortc = 8'h00;
      endcase
      if (!it.has_byte) begin
         s.len = 3'd0;
      end else if (shortc != 8'h00) begin
         s.len = 3'd2;
         s.body[0] = BSLASH_CHAR;
         s.body[1] = shortc;
      end else if (x <= CTRL_MAX || x == DEL_CHAR) begin
         s.len = 3'd6;
         s.body[0] = BSLASH_CHAR;
         s.body[1] = U_CHAR;
         s.body[2] = ZERO_CHAR;
         s.body[3] = ZERO_CHAR;
         s.body[4] = hex_digit(x[7:4]);
         s.body[5] = hex_digit(x[3:0]);
      end else if (x >= HIGH_MARK && !it.text_is_utf8) begin
         s.len = 3'd2;
         s.body[0] = LEAD_MARK | {6'd0, x[7:6]};
         s.body[1] = HIGH_MARK | (x & LOW6_MASK);
      end else begin
         s.len = 3'd1;
         s.body[0] = x;
      end
      return s;
   endfunction

endpackage

// ----- hw/rtl/jse_serializer.sv -----
// ----------------------------------------------------------------------------
// JSON string escaper serializer
// Walks one escaped segment a byte per cycle into the output register while the output is not stalled.
// ----------------------------------------------------------------------------
module jse_serializer
   import jse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       ld_valid,
   input  seg_type    ld_seg,
   output logic       ld_ready,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last
);

   logic       c_valid_ff, c_valid_in;
   seg_type    c_seg_ff;
   logic [2:0] c_idx_ff, c_idx_in;
   logic       d_valid_ff, d_valid_in;
   logic [7:0] d_byte_ff;
   logic       d_last_ff;

   logic       d_free;
   logic       c_emit;
   logic       c_last;
   logic       c_done;
   logic [3:0] c_cnt;
   logic [2:0] c_pos;
   logic [7:0] c_byte;

   assign d_free = !d_valid_ff || !rsp_stall;
   assign c_cnt  = {3'd0, c_seg_ff.starts_string} + {1'b0, c_seg_ff.len}
                 + {3'd0, c_seg_ff.ends_string};
   assign c_last = ({1'b0, c_idx_ff} == (c_cnt - 4'd1));
   assign c_emit = c_valid_ff && d_free;
   assign c_done = c_emit && c_last;
   assign ld_ready = !c_valid_ff || c_done;

   // Position inside the escaped body once the opening quote is skipped.
   assign c_pos = c_idx_ff - {2'd0, c_seg_ff.starts_string};

   always_comb begin
      if (c_seg_ff.starts_string && c_idx_ff == 3'd0) begin
         c_byte = QUOTE_CHAR;
      end else if (c_pos < c_seg_ff.len) begin
         c_byte = c_seg_ff.body[c_pos];
      end else begin
         c_byte = QUOTE_CHAR;
      end
   end

   always_comb begin
      c_valid_in = c_valid_ff;
      c_idx_in   = c_idx_ff;
      if (ld_valid && ld_ready) begin
         c_valid_in = 1'b1;
         c_idx_in   = 3'd0;
      end else if (c_done) begin
         c_valid_in = 1'b0;
      end else if (c_emit) begin
         c_idx_in = c_idx_ff + 3'd1;
      end
   end

   assign d_valid_in = d_free ? c_emit : d_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= c_valid_in;
         d_valid_ff <= d_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      c_idx_ff <= c_idx_in;
      if (ld_valid && ld_ready) begin
         c_seg_ff <= ld_seg;
      end
      if (c_emit) begin
         d_byte_ff <= c_byte;
         d_last_ff <= c_last;
      end
   end

   assign rsp_valid    = d_valid_ff;
   assign rsp_out_byte = d_byte_ff;
   assign rsp_run_last = d_last_ff;

endmodule

// ----- hw/rtl/json_string_escaper_top.sv -----
// ----------------------------------------------------------------------------
// JSON string escaper
// Turns a byte stream into JSON-quoted, escaped text, one output byte a cycle while rsp_stall is low.
// ----------------------------------------------------------------------------
// An input byte moves through an input register, an escape decode stage, a
// serializer and an output register. The output side delivers one byte per
// cycle while rsp_stall is low; an item that expands to n output bytes (one to
// eight, counting quotes) holds the serializer until all n have been emitted,
// so plain one-byte items are taken back to back while escapes and quotes make
// req_stall rise until their bytes have drained. Items that produce no output
// are dropped in the decode stage.
module json_string_escaper_top
   import jse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_has_byte,
   input  logic       req_starts_string,
   input  logic       req_ends_string,
   input  logic       req_text_is_utf8,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last
);

   logic     a_valid_ff, a_valid_in;
   item_type a_item_ff;
   logic     b_valid_ff, b_valid_in;
   seg_type  b_seg_ff;
   seg_type  a_seg;
   logic     a_nonempty;
   logic     a_adv;
   logic     b_ready;
   logic     req_take;

   jse_serializer u_ser (
      .clock        (clock),
      .reset        (reset),
      .ld_valid     (b_valid_ff),
      .ld_seg       (b_seg_ff),
      .ld_ready     (b_ready),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_last (rsp_run_last)
   );

   assign a_seg      = escape_item(a_item_ff);
   assign a_nonempty = (a_seg.len != 3'd0) || a_seg.starts_string || a_seg.ends_string;
   assign a_adv      = !b_valid_ff || b_ready;
   assign req_stall  = a_valid_ff && !a_adv;
   assign req_take   = req_valid && !req_stall;

   always_comb begin
      a_valid_in = a_valid_ff;
      b_valid_in = b_valid_ff;
      if (a_adv) begin
         b_valid_in = a_valid_ff && a_nonempty;
      end
      if (req_take) begin
         a_valid_in = 1'b1;
      end else if (a_adv) begin
         a_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         a_item_ff <= '{data_byte:     req_data_byte,
                        has_byte:      req_has_byte,
                        starts_string: req_starts_string,
                        ends_string:   req_ends_string,
                        text_is_utf8:  req_text_is_utf8};
      end
      if (a_adv) begin
         b_seg_ff <= a_seg;
      end
   end

`ifndef SYNTH
   a_empty_dropped: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> (b_seg_ff.len != 3'd0 || b_seg_ff.starts_string
                      || b_seg_ff.ends_string))
      else $error("decode stage holds an item that produces no output");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && !a_adv) |=> (a_valid_ff && $stable(a_item_ff)))
      else $error("input register changed while blocked");

   stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (a_valid_ff && b_valid_ff && !b_ready))
      else $error("input stalled with room in the pipeline");
`endif

endmodule

// ----- dv/json_string_escaper_top_tb.sv -----
// ----------------------------------------------------------------------------
// JSON string escaper testbench
// Drives byte items with random gaps, holds off the output side at random and
// once for a long stretch, and checks every output byte against a prediction
// of the quoted and escaped text, in order.
// ----------------------------------------------------------------------------
module json_string_escaper_top_tb;
   import jse_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned LongHold = 200;
   localparam int unsigned ItemsPerChunk = 44;

   // Control characters that have a short escape.
   localparam logic [7:0] BACKSPACE_CHAR = 8'h08;
   localparam logic [7:0] TAB_CHAR       = 8'h09;
   localparam logic [7:0] NEWLINE_CHAR   = 8'h0a;
   localparam logic [7:0] FORMFEED_CHAR  = 8'h0c;
   localparam logic [7:0] RETURN_CHAR    = 8'h0d;

   typedef enum int unsigned {
      IDLE_NONE,
      IDLE_FULL,
      IDLE_SPARSE
   } idle_mode_type;

   typedef struct {
      item_type    it;
      int unsigned gap;
   } pending_byte_type;

   typedef struct {
      logic [7:0] out_byte;
      logic       run_last;
   } json_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_has_byte = 1'b0;
   logic       req_starts_string = 1'b0;
   logic       req_ends_string = 1'b0;
   logic       req_text_is_utf8 = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_run_last;

   pending_byte_type byte_items[$];
   json_byte_type    expected_json[$];
   pending_byte_type staged;
   logic             staged_full = 1'b0;
   json_byte_type    want;

   logic          req_taken = 1'b0;
   logic          rsp_taken = 1'b0;
   int unsigned   items_queued = 0;
   int unsigned   items_accepted = 0;
   int unsigned   mismatches = 0;
   int unsigned   holds_asked = 0;
   int unsigned   holds_served = 0;
   int unsigned   hold_left = 0;
   int unsigned   rsp_wait = 0;
   idle_mode_type rx_mode = IDLE_FULL;
   idle_mode_type tx_mode = IDLE_FULL;

   json_string_escaper_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_has_byte      (req_has_byte),
      .req_starts_string (req_starts_string),
      .req_ends_string   (req_ends_string),
      .req_text_is_utf8  (req_text_is_utf8),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_run_last      (rsp_run_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned draw_wait(input idle_mode_type mode);
      int unsigned w;
      case (mode)
         IDLE_NONE: begin
            w = 0;
         end
         IDLE_FULL: begin
            w = $urandom_range(0, 18);
         end
         default: begin
            w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
         end
      endcase
      return w;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 40) begin
         $display("mismatch at %0t ns: %s", $time, what);
      end
   endtask

   // Appends the expected output bytes of one transfer, quotes included.
   task automatic predict_json_bytes(input item_type it);
      logic [7:0]    seq[$];
      logic [7:0]    x;
      logic [7:0]    letter;
      string         hex_chars = "0123456789abcdef";
      json_byte_type jb;
      x = it.data_byte;
      if (it.starts_string) begin
         seq.push_back(QUOTE_CHAR);
      end
      if (it.has_byte) begin
         case (x)
            QUOTE_CHAR:     letter = QUOTE_CHAR;
            BSLASH_CHAR:    letter = BSLASH_CHAR;
            BACKSPACE_CHAR: letter = "b";
            TAB_CHAR:       letter = "t";
            NEWLINE_CHAR:   letter = "n";
            FORMFEED_CHAR:  letter = "f";
            RETURN_CHAR:    letter = "r";
            default:        letter = 8'h00;
         endcase
         if (letter != 8'h00) begin
            seq.push_back(BSLASH_CHAR);
            seq.push_back(letter);
         end else if (x <= CTRL_MAX || x == DEL_CHAR) begin
            seq.push_back(BSLASH_CHAR);
            seq.push_back(U_CHAR);
            seq.push_back(ZERO_CHAR);
            seq.push_back(ZERO_CHAR);
            seq.push_back(hex_chars[x[7:4]]);
            seq.push_back(hex_chars[x[3:0]]);
         end else if (x >= HIGH_MARK && !it.text_is_utf8) begin
            seq.push_back(LEAD_MARK | {6'd0, x[7:6]});
            seq.push_back(HIGH_MARK | (x & LOW6_MASK));
         end else begin
            seq.push_back(x);
         end
      end
      if (it.ends_string) begin
         seq.push_back(QUOTE_CHAR);
      end
      foreach (seq[i]) begin
         jb.out_byte = seq[i];
         jb.run_last = (i == seq.size() - 1);
         expected_json.push_back(jb);
      end
   endtask

   // Sender: drives one pending item after its own gap, holds it while stalled.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (!staged_full && byte_items.size() != 0) begin
            staged = byte_items.pop_front();
            staged_full = 1'b1;
         end
         if (staged_full && staged.gap == 0) begin
            req_data_byte <= staged.it.data_byte;
            req_has_byte <= staged.it.has_byte;
            req_starts_string <= staged.it.starts_string;
            req_ends_string <= staged.it.ends_string;
            req_text_is_utf8 <= staged.it.text_is_utf8;
            req_valid <= 1'b1;
            staged_full = 1'b0;
         end else begin
            req_valid <= 1'b0;
            if (staged_full) begin
               staged.gap--;
            end
         end
      end
   end

   // Receiver: a random wait before each output transfer, plus the long hold
   // when the stimulus asks for one.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (holds_served != holds_asked) begin
            holds_served++;
            hold_left = LongHold;
         end
         if (rsp_taken) begin
            rsp_wait = draw_wait(rx_mode);
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_wait != 0) begin
            rsp_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Monitor: predicts on each input transfer, checks each output transfer.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         rsp_taken <= rsp_valid && !rsp_stall;
         if (req_valid && !req_stall) begin
            predict_json_bytes('{req_data_byte, req_has_byte, req_starts_string,
                                 req_ends_string, req_text_is_utf8});
            items_accepted++;
         end
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            if (expected_json.size() == 0) begin
               report_mismatch($sformatf("unexpected output byte %02h", rsp_out_byte));
            end else begin
               want = expected_json.pop_front();
               if (rsp_out_byte !== want.out_byte) begin
                  report_mismatch($sformatf("out_byte %02h, expected %02h",
                                            rsp_out_byte, want.out_byte));
               end
               if (rsp_run_last !== want.run_last) begin
                  report_mismatch($sformatf("run_last %b, expected %b on byte %02h",
                                            rsp_run_last, want.run_last, want.out_byte));
               end
            end
         end
      end
   end

   function automatic item_type make_item(input logic [7:0] data, input logic has,
                                          input logic starts, input logic ends,
                                          input logic utf8);
      item_type it;
      it.data_byte = data;
      it.has_byte = has;
      it.starts_string = starts;
      it.ends_string = ends;
      it.text_is_utf8 = utf8;
      return it;
   endfunction

   task automatic queue_item(input item_type it);
      pending_byte_type p;
      p.it = it;
      p.gap = draw_wait(tx_mode);
      byte_items.push_back(p);
      items_queued++;
   endtask

   // Byte mix weighted toward the escape classes.
   function automatic logic [7:0] pick_byte();
      logic [7:0] specials[7] = '{QUOTE_CHAR, BSLASH_CHAR, BACKSPACE_CHAR, TAB_CHAR,
                                  NEWLINE_CHAR, FORMFEED_CHAR, RETURN_CHAR};
      logic [7:0] b;
      case ($urandom_range(0, 9))
         0:       b = specials[$urandom_range(0, 6)];
         1:       b = $urandom_range(0, 31);
         2:       b = DEL_CHAR;
         3, 4:    b = $urandom_range(128, 255);
         5:       b = $urandom_range(0, 255);
         default: b = $urandom_range(32, 126);
      endcase
      return b;
   endfunction

   task automatic wait_drained();
      while (items_accepted != items_queued || expected_json.size() != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      int unsigned counted;
      int unsigned len;
      logic        utf8;
      item_type    it;

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Directed: frame-only items, every escape class, both high-byte modes.
      queue_item(make_item(8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
      queue_item(make_item(8'hff, 1'b0, 1'b1, 1'b0, 1'b1));
      queue_item(make_item(8'h5c, 1'b0, 1'b0, 1'b1, 1'b0));
      queue_item(make_item(8'hff, 1'b0, 1'b0, 1'b0, 1'b1));
      queue_item(make_item(8'h00, 1'b1, 1'b1, 1'b0, 1'b0));
      queue_item(make_item(8'h1f, 1'b1, 1'b0, 1'b0, 1'b0));
      queue_item(make_item(8'h0b, 1'b1, 1'b0, 1'b0, 1'b1));
      queue_item(make_item(QUOTE_CHAR, 1'b1, 1'b0, 1'b0, 1'b0));
      queue_item(make_item(BSLASH_CHAR, 1'b1, 1'b0, 1'b0, 1'b0));
      queue_item(make_item(BACKSPACE_CHAR, 1'b1, 1'b0, 1'b0, 1'b0));
      queue_item(make_item(TAB_CHAR, 1'b1, 1'b0, 1'b0, 1'b0));
      queue_item(make_item(NEWLINE_CHAR, 1'b1, 1'b0, 1'b0, 1'b0));
      queue_item(make_item(FORMFEED_CHAR, 1'b1, 1'b0, 1'b0, 1'b0));
      queue_item(make_item(RETURN_CHAR, 1'b1, 1'b0, 1'b0, 1'b0));
      queue_item(make_item(8'h20, 1'b1, 1'b0, 1'b0, 1'b0));
      queue_item(make_item(8'h7e, 1'b1, 1'b0, 1'b0, 1'b0));
      queue_item(make_item(HIGH_MARK, 1'b1, 1'b0, 1'b0, 1'b0));
      queue_item(make_item(8'hff, 1'b1, 1'b0, 1'b0, 1'b0));
      queue_item(make_item(HIGH_MARK, 1'b1, 1'b0, 1'b0, 1'b1));
      queue_item(make_item(8'hff, 1'b1, 1'b0, 1'b1, 1'b1));
      queue_item(make_item(DEL_CHAR, 1'b1, 1'b1, 1'b1, 1'b0));
      queue_item(make_item(8'h41, 1'b1, 1'b1, 1'b1, 1'b1));
      queue_item(make_item(8'hc3, 1'b1, 1'b1, 1'b1, 1'b0));
      wait_drained();

      // Random strings in chunks, each chunk with its own idle pattern. The
      // third chunk starts with a long output hold while the sender runs flat out.
      for (int chunk = 0; chunk < 4; chunk++) begin
         case (chunk)
            0: begin
               tx_mode = IDLE_FULL;
               rx_mode = IDLE_FULL;
            end
            1: begin
               tx_mode = IDLE_NONE;
               rx_mode = IDLE_NONE;
            end
            2: begin
               tx_mode = IDLE_NONE;
               rx_mode = IDLE_SPARSE;
               holds_asked++;
            end
            default: begin
               tx_mode = IDLE_SPARSE;
               rx_mode = IDLE_FULL;
            end
         endcase
         counted = 0;
         while (counted < ItemsPerChunk) begin
            if ($urandom_range(0, 9) == 0) begin
               // Noise: any combination of flags, including broken framing.
               it = make_item($urandom_range(0, 255), $urandom_range(0, 1),
                              $urandom_range(0, 1), $urandom_range(0, 1),
                              $urandom_range(0, 1));
               queue_item(it);
               if (it.has_byte || it.starts_string || it.ends_string) begin
                  counted++;
               end
            end else begin
               len = $urandom_range(0, 10);
               utf8 = $urandom_range(0, 1);
               if (len == 0) begin
                  queue_item(make_item($urandom_range(0, 255), 1'b0, 1'b1, 1'b1, utf8));
                  counted++;
               end
               for (int i = 0; i < len; i++) begin
                  if ($urandom_range(0, 7) == 0) begin
                     utf8 = ~utf8;
                  end
                  queue_item(make_item(pick_byte(), 1'b1, i == 0, i == len - 1, utf8));
                  counted++;
               end
            end
         end
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Timeout far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
